/* rtl/core/slle_pkg.sv */
// Shared types and constants for the singly linked list engine.
// Operation codes, status codes, field widths and the sequencer state type.
// No dependencies; imported by the core, both checkers and the testbench top.
package slle_pkg;

	// Default pool size and fixed field widths
	localparam int CAPACITY_DEF = 16;
	localparam int MODE_W       = 3;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 5;
	localparam int STATUS_W     = 3;

	// Value returned by inserts and failed requests
	localparam logic signed [VALUE_W-1:0] MINUS_ONE = '1;

	// Request operations
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DEL_AFTER  = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_BELOW = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd4;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_TAKE,
		S_LINK,
		S_VICTIM,
		S_FREE
	} state_t;

endpackage

/* rtl/core/slle_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered
// read data held until the next enabled read. No package dependency.
module slle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/singly_linked_list_engine_core.sv */
// Linked list engine: rejected requests answer from idle; pushes pass S_TAKE, plus S_LINK
// for push back onto a non-empty list; pop front S_VICTIM and S_FREE; insert/delete after
// walk to the position (one link RAM read per step), then S_TAKE and S_LINK or S_VICTIM
// and S_FREE; pop back walks, then S_FREE. One transaction at a time; start is taken in
// the cycle done shows, and the receiver cannot stall. Reset (arst_n low) empties the list
// at once: link entries at or above a high-water mark read as chained to the next node.
module singly_linked_list_engine_core
	import slle_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [POS_W-1:0]           position,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  removed_value
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	state_t state_q, state_d;

	// List pointers and pool bookkeeping
	logic [PW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d;
	logic [PW-1:0] count_q, count_d, hw_q, hw_d;
	// Walk and operation working registers
	logic [PW-1:0] cur_q, cur_d, vic_q, vic_d, nxt_q, nxt_d, new_q, new_d;
	logic [PW-1:0] lk_raddr_q;
	logic [POS_W-1:0] i_q, i_d, pos_q, pos_d;
	logic [MODE_W-1:0] mode_q, mode_d;
	logic signed [VALUE_W-1:0] val_q, val_d;
	// Result registers
	logic done_q, done_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic signed [VALUE_W-1:0] removed_value_q, removed_value_d;

	// RAM controls
	logic lk_we, lk_re, dt_we, dt_re;
	logic [PW-1:0] lk_waddr, lk_wdata, lk_raddr, dt_raddr;
	logic [PW-1:0] lk_rdata;
	logic [VALUE_W-1:0] dt_rdata;

	// Shared step unit outputs
	logic [PW-1:0] lnk;
	logic lnk_nil, empty, full, walk_more;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign removed_value = removed_value_q;

	// Link of the node read last cycle; untouched nodes are still chained in order
	assign lnk = (lk_raddr_q >= hw_q) ? PW'(lk_raddr_q + 1'b1) : lk_rdata;
	assign lnk_nil   = (lnk == NIL);
	assign empty     = (head_q == NIL);
	assign full      = (free_q >= NIL) || (count_q >= NIL);
	assign walk_more = (i_q < pos_q);

	slle_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr[AW-1:0]),
		.wdata (lk_wdata),
		.re    (lk_re),
		.raddr (lk_raddr[AW-1:0]),
		.rdata (lk_rdata)
	);

	slle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_data_ram (
		.clk   (clk),
		.we    (dt_we),
		.waddr (free_q[AW-1:0]),
		.wdata (val_q),
		.re    (dt_re),
		.raddr (dt_raddr[AW-1:0]),
		.rdata (dt_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (mode)
						MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
							if (!full) state_d = S_TAKE;
						end
						MODE_INS_AFTER: begin
							if (position != '0 && !empty && !full) state_d = S_WALK;
						end
						MODE_POP_FRONT: begin
							if (!empty) state_d = S_VICTIM;
						end
						MODE_POP_BACK: begin
							if (!empty) state_d = (head_q == tail_q) ? S_FREE : S_WALK;
						end
						MODE_DEL_AFTER: begin
							if (!empty) state_d = S_WALK;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_WALK: begin
				if (mode_q == MODE_POP_BACK) begin
					if (lnk == tail_q || lnk_nil) state_d = S_FREE;
				end else if (walk_more) begin
					if (lnk_nil) state_d = S_IDLE;
				end else if (mode_q == MODE_INS_AFTER) begin
					state_d = S_TAKE;
				end else begin
					state_d = lnk_nil ? S_IDLE : S_VICTIM;
				end
			end
			S_TAKE: begin
				if (mode_q == MODE_INS_AFTER) begin
					state_d = S_LINK;
				end else if (mode_q == MODE_PUSH_BACK && !empty) begin
					state_d = S_LINK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LINK:   state_d = S_IDLE;
			S_VICTIM: state_d = S_FREE;
			S_FREE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Datapath controls and register updates
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		free_d = free_q;
		count_d = count_q;
		hw_d = hw_q;
		cur_d = cur_q;
		vic_d = vic_q;
		nxt_d = nxt_q;
		new_d = new_q;
		i_d = i_q;
		pos_d = pos_q;
		mode_d = mode_q;
		val_d = val_q;
		done_d = 1'b0;
		status_d = status_q;
		removed_value_d = removed_value_q;
		lk_we = 1'b0;
		lk_waddr = cur_q;
		lk_wdata = NIL;
		lk_re = 1'b0;
		lk_raddr = lk_raddr_q;
		dt_we = 1'b0;
		dt_re = 1'b0;
		dt_raddr = vic_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_d = mode;
					val_d = value;
					pos_d = (position == '0) ? POS_W'(1) : position;
					removed_value_d = MINUS_ONE;
					status_d = STAT_OK;
					unique case (mode)
						MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
							if (full) begin
								done_d = 1'b1;
								status_d = STAT_FULL;
							end else begin
								lk_re = 1'b1;
								lk_raddr = free_q;
								cur_d = tail_q;
							end
						end
						MODE_INS_AFTER: begin
							priority if (position == '0) begin
								done_d = 1'b1;
								status_d = STAT_BELOW;
							end else if (empty) begin
								done_d = 1'b1;
								status_d = STAT_EMPTY;
							end else if (full) begin
								done_d = 1'b1;
								status_d = STAT_FULL;
							end else begin
								cur_d = head_q;
								i_d = POS_W'(1);
								lk_re = 1'b1;
								lk_raddr = head_q;
							end
						end
						MODE_POP_FRONT: begin
							if (empty) begin
								done_d = 1'b1;
								status_d = STAT_EMPTY;
							end else begin
								vic_d = head_q;
								lk_re = 1'b1;
								lk_raddr = head_q;
								dt_re = 1'b1;
								dt_raddr = head_q;
							end
						end
						MODE_POP_BACK: begin
							if (empty) begin
								done_d = 1'b1;
								status_d = STAT_EMPTY;
							end else begin
								vic_d = tail_q;
								dt_re = 1'b1;
								dt_raddr = tail_q;
								if (head_q == tail_q) begin
									head_d = NIL;
									tail_d = NIL;
								end else begin
									cur_d = head_q;
									lk_re = 1'b1;
									lk_raddr = head_q;
								end
							end
						end
						MODE_DEL_AFTER: begin
							if (empty) begin
								done_d = 1'b1;
								status_d = STAT_EMPTY;
							end else begin
								cur_d = head_q;
								i_d = POS_W'(1);
								lk_re = 1'b1;
								lk_raddr = head_q;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end

			// Follow one link per cycle
			S_WALK: begin
				if (mode_q == MODE_POP_BACK) begin
					if (lnk == tail_q || lnk_nil) begin
						lk_we = 1'b1;
						lk_waddr = cur_q;
						lk_wdata = NIL;
						tail_d = cur_q;
					end else begin
						cur_d = lnk;
						lk_re = 1'b1;
						lk_raddr = lnk;
					end
				end else if (walk_more) begin
					if (lnk_nil) begin
						done_d = 1'b1;
						status_d = STAT_RANGE;
					end else begin
						cur_d = lnk;
						i_d = POS_W'(i_q + 1'b1);
						lk_re = 1'b1;
						lk_raddr = lnk;
					end
				end else if (mode_q == MODE_INS_AFTER) begin
					nxt_d = lnk;
					lk_re = 1'b1;
					lk_raddr = free_q;
				end else if (lnk_nil) begin
					done_d = 1'b1;
					status_d = STAT_RANGE;
				end else begin
					vic_d = lnk;
					lk_re = 1'b1;
					lk_raddr = lnk;
					dt_re = 1'b1;
					dt_raddr = lnk;
				end
			end

			// Allocate the free head node and write its value and link
			S_TAKE: begin
				dt_we = 1'b1;
				lk_we = 1'b1;
				lk_waddr = free_q;
				new_d = free_q;
				free_d = lnk;
				count_d = PW'(count_q + 1'b1);
				if (free_q >= hw_q) hw_d = PW'(hw_q + 1'b1);
				unique case (mode_q)
					MODE_PUSH_FRONT: begin
						lk_wdata = empty ? NIL : head_q;
						head_d = free_q;
						if (empty) tail_d = free_q;
						done_d = 1'b1;
					end
					MODE_PUSH_BACK: begin
						lk_wdata = NIL;
						tail_d = free_q;
						if (empty) begin
							head_d = free_q;
							done_d = 1'b1;
						end
					end
					default: begin
						lk_wdata = nxt_q;
						if (nxt_q == NIL) tail_d = free_q;
					end
				endcase
			end

			// Hook the new node behind its predecessor
			S_LINK: begin
				lk_we = 1'b1;
				lk_waddr = cur_q;
				lk_wdata = new_q;
				done_d = 1'b1;
			end

			// Unlink the victim node
			S_VICTIM: begin
				if (mode_q == MODE_POP_FRONT) begin
					head_d = lnk;
					if (lnk_nil) tail_d = NIL;
				end else begin
					lk_we = 1'b1;
					lk_waddr = cur_q;
					lk_wdata = lnk;
					if (lnk_nil) tail_d = cur_q;
				end
			end

			// Return the victim to the front of the free chain
			S_FREE: begin
				lk_we = 1'b1;
				lk_waddr = vic_q;
				lk_wdata = free_q;
				free_d = vic_q;
				if (count_q != '0) count_d = PW'(count_q - 1'b1);
				done_d = 1'b1;
				removed_value_d = $signed(dt_rdata);
			end

			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= NIL;
			tail_q <= NIL;
			free_q <= '0;
			count_q <= '0;
			hw_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			free_q <= free_d;
			count_q <= count_d;
			hw_q <= hw_d;
			done_q <= done_d;
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		vic_q <= vic_d;
		nxt_q <= nxt_d;
		new_q <= new_d;
		i_q <= i_d;
		pos_q <= pos_d;
		mode_q <= mode_d;
		val_q <= val_d;
		status_q <= status_d;
		removed_value_q <= removed_value_d;
		if (lk_re) begin
			lk_raddr_q <= lk_raddr;
		end
	end

endmodule

/* rtl/core/slle_checker.sv */
// Port-level checks for the linked list engine core, bound into the engine core.
// Depends on slle_pkg for field widths and codes.
module slle_checker
	import slle_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [MODE_W-1:0]         mode,
	input logic                      done,
	input logic [STATUS_W-1:0]       status,
	input logic signed [VALUE_W-1:0] removed_value
);

	// A finished transaction frees the engine in the same cycle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// An accepted request either starts work or reports at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request made no progress");

	// Unknown operations are answered next cycle as ignored
	a_unknown_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode > MODE_DEL_AFTER)) |=>
		(done && status == STAT_OK && removed_value == MINUS_ONE))
		else $error("unknown mode not ignored");

	// Failures carry minus one
	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (removed_value == MINUS_ONE))
		else $error("failed request returned a value");

	// Status stays within the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_OK || status == STAT_EMPTY || status == STAT_BELOW ||
			status == STAT_RANGE || status == STAT_FULL))
		else $error("undefined status code");

endmodule

bind singly_linked_list_engine_core slle_checker u_slle_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.mode          (mode),
	.done          (done),
	.status        (status),
	.removed_value (removed_value)
);

/* test/slle_list_checker.sv */
// Checker for the singly linked list engine: predicts each result from the requests it sees.
// Tracks its own node pool and compares every done strobe with the oldest prediction.
// Depends on slle_pkg for widths, operation codes and status codes.
module slle_list_checker
	import slle_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [POS_W-1:0]          position,
	input  logic                      done,
	input  logic [STATUS_W-1:0]       status,
	input  logic signed [VALUE_W-1:0] removed_value,
	output int unsigned               fail_count,
	output int unsigned               open_count
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [POS_W-1:0] node_ptr_t;

	typedef struct packed {
		logic [STATUS_W-1:0]         status;
		logic signed [VALUE_W-1:0]   value;
	} list_result_t;

	localparam node_ptr_t NIL = node_ptr_t'(CAPACITY);

	// Shadow copy of the node pool
	logic signed [VALUE_W-1:0] node_val [CAPACITY];
	node_ptr_t                 node_next [CAPACITY];
	node_ptr_t                 head_ptr;
	node_ptr_t                 tail_ptr;
	node_ptr_t                 free_ptr;
	int                        node_total;

	list_result_t pending_results [$];

	function automatic node_ptr_t next_of(node_ptr_t n);
		return (n < NIL) ? node_next[n] : NIL;
	endfunction

	// Pop a node off the free chain and write its value
	function automatic node_ptr_t grab_node(logic signed [VALUE_W-1:0] v);
		node_ptr_t n;
		n = free_ptr;
		if (n >= NIL || node_total >= CAPACITY)
			return NIL;
		free_ptr = node_next[n];
		node_val[n] = v;
		node_total++;
		return n;
	endfunction

	// Push a node back to the front of the free chain
	function automatic void release_node(node_ptr_t n);
		if (n >= NIL)
			return;
		node_next[n] = free_ptr;
		free_ptr = n;
		if (node_total > 0)
			node_total--;
	endfunction

	// Node at 1-based position p, or NIL when the list is shorter
	function automatic node_ptr_t walk_to(int p);
		node_ptr_t cur;
		int i;
		cur = head_ptr;
		i = 1;
		while (cur != NIL && i < p && i <= CAPACITY) begin
			cur = next_of(cur);
			i++;
		end
		if (i < p)
			return NIL;
		return cur;
	endfunction

	// Apply one request to the shadow list and return the result it gives
	function automatic list_result_t apply_list_op(logic [MODE_W-1:0] op,
			logic signed [VALUE_W-1:0] din, logic [POS_W-1:0] pos);
		list_result_t r;
		node_ptr_t n, cur, victim;
		bit was_empty;
		int steps;
		r.status = STAT_OK;
		r.value = MINUS_ONE;
		was_empty = (head_ptr == NIL);
		case (op)
			MODE_PUSH_FRONT: begin
				n = grab_node(din);
				if (n == NIL) begin
					r.status = STAT_FULL;
				end else begin
					node_next[n] = was_empty ? NIL : head_ptr;
					head_ptr = n;
					if (was_empty)
						tail_ptr = n;
				end
			end
			MODE_PUSH_BACK: begin
				n = grab_node(din);
				if (n == NIL) begin
					r.status = STAT_FULL;
				end else begin
					node_next[n] = NIL;
					if (was_empty)
						head_ptr = n;
					else if (tail_ptr < NIL)
						node_next[tail_ptr] = n;
					tail_ptr = n;
				end
			end
			MODE_INS_AFTER: begin
				if (pos < 1) begin
					r.status = STAT_BELOW;
				end else if (was_empty) begin
					r.status = STAT_EMPTY;
				end else if (free_ptr >= NIL || node_total >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					cur = walk_to(int'(pos));
					if (cur == NIL) begin
						r.status = STAT_RANGE;
					end else begin
						n = grab_node(din);
						node_next[n] = next_of(cur);
						node_next[cur] = n;
						if (node_next[n] == NIL)
							tail_ptr = n;
					end
				end
			end
			MODE_POP_FRONT: begin
				if (was_empty) begin
					r.status = STAT_EMPTY;
				end else begin
					victim = head_ptr;
					r.value = node_val[victim];
					head_ptr = next_of(victim);
					if (head_ptr == NIL)
						tail_ptr = NIL;
					release_node(victim);
				end
			end
			MODE_POP_BACK: begin
				if (was_empty) begin
					r.status = STAT_EMPTY;
				end else begin
					victim = tail_ptr;
					r.value = node_val[victim];
					if (head_ptr == tail_ptr) begin
						head_ptr = NIL;
						tail_ptr = NIL;
					end else begin
						// find the node in front of the tail
						steps = 0;
						cur = head_ptr;
						while (cur != NIL && next_of(cur) != victim && steps < CAPACITY) begin
							cur = next_of(cur);
							steps++;
						end
						if (cur < NIL)
							node_next[cur] = NIL;
						tail_ptr = cur;
					end
					release_node(victim);
				end
			end
			MODE_DEL_AFTER: begin
				if (was_empty) begin
					r.status = STAT_EMPTY;
				end else begin
					// a position below one acts as the first node
					cur = walk_to((pos < 1) ? 1 : int'(pos));
					if (cur == NIL || next_of(cur) == NIL) begin
						r.status = STAT_RANGE;
					end else begin
						victim = next_of(cur);
						r.value = node_val[victim];
						node_next[cur] = next_of(victim);
						if (node_next[cur] == NIL)
							tail_ptr = cur;
						release_node(victim);
					end
				end
			end
			default: begin
				// unused modes leave the list alone
			end
		endcase
		return r;
	endfunction

	// Predict on accept, compare on done
	always @(posedge clk or negedge arst_n) begin : track
		int errs;
		list_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				node_val[i] = '0;
				node_next[i] = node_ptr_t'(i + 1);
			end
			head_ptr = NIL;
			tail_ptr = NIL;
			free_ptr = '0;
			node_total = 0;
			pending_results.delete();
			fail_count <= 0;
			open_count <= 0;
		end else begin
			errs = 0;
			if (done) begin
				if (pending_results.size() == 0) begin
					errs++;
					$display("%0t: result with no transaction open: expected none, actual %0d/%0d",
						$time, status, removed_value);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						errs++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, status);
					end
					if (removed_value !== want.value) begin
						errs++;
						$display("%0t: removed_value mismatch: expected %0d, actual %0d",
							$time, want.value, removed_value);
					end
				end
			end
			if (start && !busy)
				pending_results.push_back(apply_list_op(mode, value, position));
			fail_count <= fail_count + errs;
			open_count <= pending_results.size();
		end
	end

endmodule

/* test/tb_top.sv */
// Top of the linked list engine testbench: clock, reset, request stimulus and verdict.
// Instantiates singly_linked_list_engine_core beside slle_list_checker.
// Depends on slle_pkg for operation codes and field widths.
module tb_top
	import slle_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 800;
	localparam int QUIET_TAIL   = 100;
	localparam int STALL_LIMIT  = 500;
	localparam int DRAIN_CYCLES = 24;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [MODE_W-1:0]         mode = MODE_PUSH_FRONT;
	logic signed [VALUE_W-1:0] value = '0;
	logic [POS_W-1:0]          position = '0;
	logic                      done;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] removed_value;
	int unsigned               fail_count;
	int unsigned               open_count;
	int                        stall_cycles = 0;
	bit                        gaps_on = 1'b1;

	singly_linked_list_engine_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.value         (value),
		.position      (position),
		.done          (done),
		.status        (status),
		.removed_value (removed_value)
	);

	slle_list_checker u_list_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.value         (value),
		.position      (position),
		.done          (done),
		.status        (status),
		.removed_value (removed_value),
		.fail_count    (fail_count),
		.open_count    (open_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// Issue one request, with an optional idle burst first, and hold it until taken
	task automatic issue_request(input logic [MODE_W-1:0] m,
			input logic signed [VALUE_W-1:0] v, input logic [POS_W-1:0] p);
		int gap;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		value <= v;
		position <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Value with the extremes showing up now and then
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return MINUS_ONE;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		bit growing;
		int phase_left;
		int roll;
		logic [MODE_W-1:0] m;
		logic [POS_W-1:0] p;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every removal and the insert-after checks
		issue_request(MODE_POP_FRONT, 32'sd5, 5'd0);
		issue_request(MODE_POP_BACK, 32'sd5, 5'd0);
		issue_request(MODE_DEL_AFTER, 32'sd5, 5'd1);
		issue_request(MODE_INS_AFTER, 32'sd5, 5'd0);
		issue_request(MODE_INS_AFTER, 32'sd5, 5'd1);
		// unused modes
		issue_request(3'd6, 32'sd9, 5'd3);
		issue_request(3'd7, 32'sd9, 5'd31);
		// build a short list with extreme values
		issue_request(MODE_PUSH_FRONT, 32'sh8000_0000, 5'd0);
		issue_request(MODE_PUSH_BACK, 32'sh7FFF_FFFF, 5'd31);
		issue_request(MODE_INS_AFTER, MINUS_ONE, 5'd2);
		issue_request(MODE_INS_AFTER, 32'sd77, 5'd4);
		issue_request(MODE_INS_AFTER, 32'sd78, 5'd0);
		issue_request(MODE_INS_AFTER, 32'sd0, 5'd1);
		// remove after: position below one, past the tail, far out
		issue_request(MODE_DEL_AFTER, 32'sd0, 5'd0);
		issue_request(MODE_DEL_AFTER, 32'sd0, 5'd3);
		issue_request(MODE_DEL_AFTER, 32'sd0, 5'd31);
		issue_request(MODE_DEL_AFTER, 32'sd0, 5'd2);
		// drain down to empty through the back and the front
		issue_request(MODE_POP_BACK, 32'sd0, 5'd0);
		issue_request(MODE_POP_BACK, 32'sd0, 5'd0);
		issue_request(MODE_POP_FRONT, 32'sd0, 5'd0);
		issue_request(MODE_PUSH_FRONT, 32'sd1, 5'd0);
		issue_request(MODE_POP_FRONT, 32'sd0, 5'd0);

		// Random part: alternate fill and drain phases so the pool fills and empties
		growing = 1'b1;
		phase_left = $urandom_range(25, 50);
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS - QUIET_TAIL)
				gaps_on = 1'b0;
			if (phase_left == 0) begin
				growing = !growing;
				phase_left = $urandom_range(25, 50);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				m = 3'($urandom_range(6, 7));
			else if ((roll < 75) == growing)
				m = 3'($urandom_range(MODE_PUSH_FRONT, MODE_INS_AFTER));
			else
				m = 3'($urandom_range(MODE_POP_FRONT, MODE_DEL_AFTER));
			if ($urandom_range(0, 4) == 0)
				p = 5'($urandom_range(0, 31));
			else
				p = 5'($urandom_range(0, 17));
			issue_request(m, pick_value(), p);
		end
		start <= 1'b0;

		// Wait for every open transaction, then let the block settle
		while (open_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
